// ===== sv/hexinv_pkg.sv =====
// Package for the hexahedron inverse mapping block: fixed-point constants,
// datapath command codes, the controller/datapath command and status structs.
// No dependencies; every other file of the block imports it.
package hexinv_pkg;

  localparam int FRAC_BITS  = 24;
  localparam int PASS_LIMIT = 100;
  localparam int PASS_W     = 7;

  // Width of the squared axis length after the fraction shift.
  localparam int LEN_W = 64 - FRAC_BITS;
  // Dividend width: 2^(2F) plus half of the divisor.
  localparam int NUM_W = ((2 * FRAC_BITS > LEN_W - 1) ? 2 * FRAC_BITS : LEN_W - 1) + 1;
  // Accumulator width: eight rounded products plus headroom.
  localparam int ACC_W = 64 - FRAC_BITS + 4;

  localparam longint ONE_L = longint'(1) << FRAC_BITS;
  localparam logic signed [31:0] ONE_Q  = 32'(ONE_L);
  localparam logic signed [31:0] DAMP_Q = 32'((9 * ONE_L + 5) / 10);
  localparam logic signed [31:0] EDGE_Q = 32'(3 * (ONE_L / 2));
  localparam logic signed [31:0] S32_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] S32_MIN = 32'sh8000_0000;

  // Status codes carried on each result word.
  localparam logic [1:0] ST_FOUND   = 2'd0;
  localparam logic [1:0] ST_OUTSIDE = 2'd1;
  localparam logic [1:0] ST_LIMIT   = 2'd2;

  // Datapath operations issued by the controller.
  typedef enum logic [4:0] {
    OP_NOP, OP_LOAD, OP_START, OP_AXCLR, OP_AXADD, OP_AXST, OP_AXSQ,
    OP_DIVGO, OP_DIVST, OP_LCLR, OP_PCLR, OP_SH1, OP_SH2, OP_ACLR,
    OP_MAP, OP_DX, OP_SQ, OP_CR, OP_CI, OP_CD, OP_LU, OP_EMIT
  } op_t;

  typedef struct packed {
    op_t        op;
    logic [1:0] n;     // axis being derived
    logic [1:0] d;     // coordinate direction
    logic [2:0] k;     // corner, face term or projection term
    logic [1:0] stat;  // status for emitted words
  } cmd_t;

  typedef struct packed {
    logic div_done;
    logic dist_below;
    logic outside;
    logic out_free;
  } sts_t;

  // Saturate a 64-bit signed value to 32 bits.
  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    if (v > 64'sd2147483647) begin
      return S32_MAX;
    end else if (v < -64'sd2147483648) begin
      return S32_MIN;
    end
    return v[31:0];
  endfunction

  // Round to nearest, half up, dropping the fraction bits.
  function automatic logic signed [63:0] rnd(input logic signed [63:0] v);
    return (v + (64'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
  endfunction

  // Corners of the positive (j < 4) and negative (j >= 4) faces of axis n.
  function automatic logic [2:0] face_corner(input logic [1:0] n, input logic [2:0] j);
    logic [2:0] c;
    unique case ({n, j})
      5'b00_000: c = 3'd1;
      5'b00_001: c = 3'd2;
      5'b00_010: c = 3'd5;
      5'b00_011: c = 3'd6;
      5'b00_100: c = 3'd0;
      5'b00_101: c = 3'd3;
      5'b00_110: c = 3'd4;
      5'b00_111: c = 3'd7;
      5'b01_000: c = 3'd2;
      5'b01_001: c = 3'd3;
      5'b01_010: c = 3'd6;
      5'b01_011: c = 3'd7;
      5'b01_100: c = 3'd0;
      5'b01_101: c = 3'd1;
      5'b01_110: c = 3'd4;
      5'b01_111: c = 3'd5;
      5'b10_000: c = 3'd4;
      5'b10_001: c = 3'd5;
      5'b10_010: c = 3'd6;
      5'b10_011: c = 3'd7;
      5'b10_100: c = 3'd0;
      5'b10_101: c = 3'd1;
      5'b10_110: c = 3'd2;
      5'b10_111: c = 3'd3;
      default:   c = 3'd0;
    endcase
    return c;
  endfunction

endpackage

// ===== sv/hexinv_div.sv =====
// Restoring divider for the inverse squared axis lengths, one quotient bit
// per cycle. Depends on hexinv_pkg.
module hexinv_div (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [hexinv_pkg::LEN_W-1:0]  den,
  output logic                          done,
  output logic signed [31:0]            quo
);
  import hexinv_pkg::*;

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic [NUM_W-1:0] num_r;
  logic [NUM_W-1:0] q_r;
  logic [LEN_W-1:0] rem_r;
  logic [LEN_W-1:0] den_r;
  logic [CNT_W-1:0] cnt_r;
  logic             busy_r;
  logic             done_r;
  logic [LEN_W:0]   trial;
  logic             fits;

  // Shift in the next dividend bit and try the subtraction.
  assign trial = {rem_r, num_r[NUM_W-1]};
  assign fits  = trial >= {1'b0, den_r};

  // Control: busy and done flags.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      done_r <= 1'b0;
      cnt_r  <= CNT_W'(NUM_W);
    end else if (busy_r) begin
      cnt_r <= cnt_r - 1'b1;
      if (cnt_r == CNT_W'(1)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  // Datapath: dividend 2^(2F) + den/2 for a rounded quotient.
  always_ff @(posedge clk) begin
    if (start) begin
      num_r <= (NUM_W'(1) << (2 * FRAC_BITS)) + NUM_W'(den >> 1);
      den_r <= den;
      rem_r <= '0;
      q_r   <= '0;
    end else if (busy_r) begin
      num_r <= num_r << 1;
      q_r   <= {q_r[NUM_W-2:0], fits};
      rem_r <= fits ? LEN_W'(trial - {1'b0, den_r}) : trial[LEN_W-1:0];
    end
  end

  // A zero divisor yields all ones, which saturates like any large quotient.
  assign done = done_r;
  assign quo  = (q_r[NUM_W-1:31] != '0) ? S32_MAX : signed'(q_r[31:0]);

endmodule

// ===== sv/hexinv_dp.sv =====
// Datapath of the hexahedron inverse mapping: corner store, axis and weight
// registers, one shared 32x32 multiplier, divider and output register.
// Depends on hexinv_pkg and hexinv_div.
module hexinv_dp (
  input  logic                     clk,
  input  logic                     rst_n,
  input  hexinv_pkg::cmd_t         cmd,
  output hexinv_pkg::sts_t         sts,
  input  logic [2:0]               in_corner,
  input  logic signed [31:0]       in_coord_x,
  input  logic signed [31:0]       in_coord_y,
  input  logic signed [31:0]       in_coord_z,
  input  logic [30:0]              in_limit,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [2:0]               out_index,
  output logic signed [31:0]       out_weight,
  output logic [1:0]               out_status,
  output logic                     out_last
);
  import hexinv_pkg::*;

  logic signed [31:0] corner_r [24];
  logic signed [31:0] axis_r [9];
  logic signed [31:0] inv_r [3];
  logic signed [31:0] local_r [3];
  logic signed [31:0] pt_r [3];
  logic signed [31:0] dx_r [3];
  logic signed [31:0] w_r [8];
  logic [30:0]        limit_r;
  logic signed [31:0] t_r;
  logic signed [31:0] corr_r;
  logic signed [ACC_W-1:0] acc_r;
  logic [63:0]        len_r;
  logic [63:0]        dist_r;
  logic               outside_r;
  logic signed [63:0] p_r;
  cmd_t               wb_r;

  logic               out_valid_r;
  logic [2:0]         out_index_r;
  logic signed [31:0] out_weight_r;
  logic [1:0]         out_status_r;
  logic               out_last_r;

  logic [4:0]         c_addr;
  logic [3:0]         ax_idx;
  logic signed [31:0] rd_corner;
  logic signed [31:0] rd_axis;
  logic signed [31:0] a_op;
  logic signed [31:0] b_op;
  logic signed [31:0] fac [3];
  logic signed [63:0] pr;
  logic signed [63:0] acc64;
  logic signed [31:0] acc_sat;
  logic signed [31:0] pr_sat;
  logic signed [31:0] w_new;
  logic signed [31:0] axis_new;
  logic signed [31:0] dx_new;
  logic signed [31:0] l_new;
  logic               div_done;
  logic signed [31:0] div_quo;

  // Read addresses for the corner store and the axis registers.
  always_comb begin
    if (cmd.op == OP_AXADD) begin
      c_addr = 5'(face_corner(cmd.n, cmd.k)) * 5'd3 + 5'(cmd.d);
    end else begin
      c_addr = 5'(cmd.k) * 5'd3 + 5'(cmd.d);
    end
    if (cmd.op == OP_CR) begin
      ax_idx = 4'(cmd.d) * 4'd3 + 4'(cmd.k[1:0]);
    end else begin
      ax_idx = 4'(cmd.n) * 4'd3 + 4'(cmd.d);
    end
  end
  assign rd_corner = corner_r[c_addr];
  assign rd_axis   = axis_r[ax_idx];

  // Linear shape factors (1 +/- xi) of the current corner.
  always_comb begin
    logic signed [63:0] l64;
    logic               pos;
    for (int j = 0; j < 3; j++) begin
      l64 = 64'(local_r[j]);
      unique case (j)
        0:       pos = cmd.k[0] ^ cmd.k[1];
        1:       pos = cmd.k[1];
        default: pos = cmd.k[2];
      endcase
      fac[j] = sat32(pos ? 64'(ONE_Q) + l64 : 64'(ONE_Q) - l64);
    end
  end

  // Rounded views of the product and the accumulator.
  assign pr      = rnd(p_r);
  assign pr_sat  = sat32(pr);
  assign acc64   = 64'(acc_r);
  assign acc_sat = sat32(acc64);
  assign w_new   = sat32((64'(pr_sat) + 64'sd4) >>> 3);
  assign axis_new = sat32((acc64 + 64'sd4) >>> 3);
  assign dx_new  = sat32(64'(pt_r[cmd.d]) - 64'(acc_sat));
  assign l_new   = sat32(64'(local_r[cmd.d]) + 64'(corr_r));

  // Multiplier operand selection.
  always_comb begin
    a_op = '0;
    b_op = '0;
    unique case (cmd.op)
      OP_AXSQ: begin a_op = rd_axis;   b_op = rd_axis;       end
      OP_SH1:  begin a_op = fac[0];    b_op = fac[1];        end
      OP_SH2:  begin a_op = t_r;       b_op = fac[2];        end
      OP_MAP:  begin a_op = rd_corner; b_op = w_r[cmd.k];    end
      OP_SQ:   begin a_op = dx_r[cmd.d]; b_op = dx_r[cmd.d]; end
      OP_CR:   begin a_op = dx_r[cmd.k[1:0]]; b_op = rd_axis; end
      OP_CI:   begin a_op = acc_sat;   b_op = inv_r[cmd.d];  end
      OP_CD:   begin a_op = corr_r;    b_op = DAMP_Q;        end
      default: begin a_op = '0;        b_op = '0;            end
    endcase
  end

  // Product register and the command that will consume it.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wb_r <= '{op: OP_NOP, default: '0};
    end else begin
      wb_r <= cmd;
    end
    p_r <= 64'(a_op) * 64'(b_op);
  end

  // Direct operations and product writeback.
  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_LOAD: begin
        corner_r[5'(in_corner) * 5'd3]        <= in_coord_x;
        corner_r[5'(in_corner) * 5'd3 + 5'd1] <= in_coord_y;
        corner_r[5'(in_corner) * 5'd3 + 5'd2] <= in_coord_z;
      end
      OP_START: begin
        pt_r[0] <= in_coord_x;
        pt_r[1] <= in_coord_y;
        pt_r[2] <= in_coord_z;
        limit_r <= in_limit;
      end
      OP_AXCLR: begin
        acc_r <= '0;
        if (cmd.d == 2'd0) begin
          len_r <= '0;
        end
      end
      OP_AXADD: begin
        if (!cmd.k[2]) begin
          acc_r <= acc_r + ACC_W'(rd_corner);
        end else begin
          acc_r <= acc_r - ACC_W'(rd_corner);
        end
      end
      OP_AXST: axis_r[ax_idx] <= axis_new;
      OP_DIVST: inv_r[cmd.n] <= div_quo;
      OP_LCLR: begin
        local_r[0] <= '0;
        local_r[1] <= '0;
        local_r[2] <= '0;
      end
      OP_PCLR: begin
        dist_r    <= '0;
        outside_r <= 1'b0;
      end
      OP_ACLR: acc_r <= '0;
      OP_DX: dx_r[cmd.d] <= dx_new;
      OP_LU: begin
        local_r[cmd.d] <= l_new;
        if (l_new > EDGE_Q || l_new < -EDGE_Q) begin
          outside_r <= 1'b1;
        end
      end
      default: ;
    endcase

    case (wb_r.op)
      OP_AXSQ: len_r  <= len_r + unsigned'(p_r);
      OP_SH1:  t_r    <= pr_sat;
      OP_SH2:  w_r[wb_r.k] <= w_new;
      OP_MAP,
      OP_CR:   acc_r  <= acc_r + signed'(pr[ACC_W-1:0]);
      OP_SQ:   dist_r <= dist_r + unsigned'(p_r);
      OP_CI,
      OP_CD:   corr_r <= pr_sat;
      default: ;
    endcase
  end

  // Inverse squared axis length.
  hexinv_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.op == OP_DIVGO),
    .den   (len_r[63:FRAC_BITS]),
    .done  (div_done),
    .quo   (div_quo)
  );

  // Output word register; a new word loads when the slot is free.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.op == OP_EMIT) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == OP_EMIT) begin
      out_index_r  <= cmd.k;
      out_weight_r <= w_r[cmd.k];
      out_status_r <= cmd.stat;
      out_last_r   <= (cmd.k == 3'd7);
    end
  end

  assign out_valid  = out_valid_r;
  assign out_index  = out_index_r;
  assign out_weight = out_weight_r;
  assign out_status = out_status_r;
  assign out_last   = out_last_r;

  // Status back to the controller.
  assign sts.div_done   = div_done;
  assign sts.dist_below = (dist_r >> FRAC_BITS) < 64'(limit_r);
  assign sts.outside    = outside_r;
  assign sts.out_free   = !out_valid_r || out_ready;

endmodule

// ===== sv/hexinv_ctrl.sv =====
// Controller of the hexahedron inverse mapping: sequences axis derivation,
// the Newton-style passes and the output words. Depends on hexinv_pkg.
module hexinv_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_func,
  output logic              in_ready,
  input  hexinv_pkg::sts_t  sts,
  output hexinv_pkg::cmd_t  cmd
);
  import hexinv_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE, S_AX_CLR, S_AX_ADD, S_AX_ST, S_AX_SQ, S_AX_SQW, S_DIV_GO,
    S_DIV_WAIT, S_DIV_ST, S_LCLR, S_PASS, S_SH1, S_SH1W, S_SH2, S_SH2W,
    S_MCLR, S_MAP, S_MAPW, S_DX, S_SQ, S_SQW, S_CCLR, S_CR, S_CRW,
    S_CI, S_CIW, S_CD, S_CDW, S_LU, S_DECIDE, S_EMIT
  } state_t;

  state_t            state_r, state_nxt;
  logic [1:0]        n_r, n_nxt;
  logic [1:0]        d_r, d_nxt;
  logic [2:0]        k_r, k_nxt;
  logic [PASS_W-1:0] cnt_r, cnt_nxt;
  logic [1:0]        stat_r, stat_nxt;

  // Next state, counters and the datapath command.
  always_comb begin
    state_nxt = state_r;
    n_nxt     = n_r;
    d_nxt     = d_r;
    k_nxt     = k_r;
    cnt_nxt   = cnt_r;
    stat_nxt  = stat_r;
    cmd       = '{op: OP_NOP, n: n_r, d: d_r, k: k_r, stat: stat_r};
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          if (in_func) begin
            cmd.op    = OP_START;
            n_nxt     = '0;
            d_nxt     = '0;
            state_nxt = S_AX_CLR;
          end else begin
            cmd.op = OP_LOAD;
          end
        end
      end
      S_AX_CLR: begin
        cmd.op    = OP_AXCLR;
        k_nxt     = '0;
        state_nxt = S_AX_ADD;
      end
      S_AX_ADD: begin
        cmd.op = OP_AXADD;
        k_nxt  = k_r + 1'b1;
        if (k_r == 3'd7) begin
          state_nxt = S_AX_ST;
        end
      end
      S_AX_ST: begin
        cmd.op    = OP_AXST;
        state_nxt = S_AX_SQ;
      end
      S_AX_SQ: begin
        cmd.op    = OP_AXSQ;
        state_nxt = S_AX_SQW;
      end
      S_AX_SQW: begin
        if (d_r == 2'd2) begin
          state_nxt = S_DIV_GO;
        end else begin
          d_nxt     = d_r + 1'b1;
          state_nxt = S_AX_CLR;
        end
      end
      S_DIV_GO: begin
        cmd.op    = OP_DIVGO;
        state_nxt = S_DIV_WAIT;
      end
      S_DIV_WAIT: begin
        if (sts.div_done) begin
          state_nxt = S_DIV_ST;
        end
      end
      S_DIV_ST: begin
        cmd.op = OP_DIVST;
        d_nxt  = '0;
        if (n_r == 2'd2) begin
          cnt_nxt   = '0;
          state_nxt = S_LCLR;
        end else begin
          n_nxt     = n_r + 1'b1;
          state_nxt = S_AX_CLR;
        end
      end
      S_LCLR: begin
        cmd.op    = OP_LCLR;
        state_nxt = S_PASS;
      end
      S_PASS: begin
        cmd.op    = OP_PCLR;
        k_nxt     = '0;
        state_nxt = S_SH1;
      end
      S_SH1: begin
        cmd.op    = OP_SH1;
        state_nxt = S_SH1W;
      end
      S_SH1W: state_nxt = S_SH2;
      S_SH2: begin
        cmd.op    = OP_SH2;
        state_nxt = S_SH2W;
      end
      S_SH2W: begin
        k_nxt = k_r + 1'b1;
        if (k_r == 3'd7) begin
          d_nxt     = '0;
          state_nxt = S_MCLR;
        end else begin
          state_nxt = S_SH1;
        end
      end
      S_MCLR: begin
        cmd.op    = OP_ACLR;
        k_nxt     = '0;
        state_nxt = S_MAP;
      end
      S_MAP: begin
        cmd.op    = OP_MAP;
        state_nxt = S_MAPW;
      end
      S_MAPW: begin
        k_nxt     = k_r + 1'b1;
        state_nxt = (k_r == 3'd7) ? S_DX : S_MAP;
      end
      S_DX: begin
        cmd.op    = OP_DX;
        state_nxt = S_SQ;
      end
      S_SQ: begin
        cmd.op    = OP_SQ;
        state_nxt = S_SQW;
      end
      S_SQW: begin
        if (d_r == 2'd2) begin
          d_nxt     = '0;
          state_nxt = S_CCLR;
        end else begin
          d_nxt     = d_r + 1'b1;
          state_nxt = S_MCLR;
        end
      end
      S_CCLR: begin
        cmd.op    = OP_ACLR;
        k_nxt     = '0;
        state_nxt = S_CR;
      end
      S_CR: begin
        cmd.op    = OP_CR;
        state_nxt = S_CRW;
      end
      S_CRW: begin
        k_nxt     = k_r + 1'b1;
        state_nxt = (k_r == 3'd2) ? S_CI : S_CR;
      end
      S_CI: begin
        cmd.op    = OP_CI;
        state_nxt = S_CIW;
      end
      // The first pass applies the correction undamped.
      S_CIW: state_nxt = (cnt_r == '0) ? S_LU : S_CD;
      S_CD: begin
        cmd.op    = OP_CD;
        state_nxt = S_CDW;
      end
      S_CDW: state_nxt = S_LU;
      S_LU: begin
        cmd.op = OP_LU;
        if (d_r == 2'd2) begin
          state_nxt = S_DECIDE;
        end else begin
          d_nxt     = d_r + 1'b1;
          state_nxt = S_CCLR;
        end
      end
      // Found takes priority over leaving the element, then the pass limit.
      S_DECIDE: begin
        k_nxt = '0;
        if (cnt_r != '0 && sts.dist_below) begin
          stat_nxt  = ST_FOUND;
          state_nxt = S_EMIT;
        end else if (sts.outside) begin
          stat_nxt  = ST_OUTSIDE;
          state_nxt = S_EMIT;
        end else if (cnt_r > PASS_W'(PASS_LIMIT)) begin
          stat_nxt  = ST_LIMIT;
          state_nxt = S_EMIT;
        end else begin
          cnt_nxt   = cnt_r + 1'b1;
          state_nxt = S_PASS;
        end
      end
      S_EMIT: begin
        if (sts.out_free) begin
          cmd.op = OP_EMIT;
          k_nxt  = k_r + 1'b1;
          if (k_r == 3'd7) begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // State and counters.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      n_r     <= '0;
      d_r     <= '0;
      k_r     <= '0;
      cnt_r   <= '0;
      stat_r  <= ST_FOUND;
    end else begin
      state_r <= state_nxt;
      n_r     <= n_nxt;
      d_r     <= d_nxt;
      k_r     <= k_nxt;
      cnt_r   <= cnt_nxt;
      stat_r  <= stat_nxt;
    end
  end

  assign in_ready = (state_r == S_IDLE);

endmodule

// ===== sv/hex_element_inverse_mapping_top.sv =====
// Top level of the hexahedron inverse mapping block: stream ports, field
// packing, controller and datapath. Depends on hexinv_pkg, hexinv_ctrl, hexinv_dp.

// Locates a point in one eight-node hexahedral element by iterating trilinear
// local coordinates from the element center. A load word (tuser 0) stores one
// corner. A locate word (tuser 1) returns eight result words, one trilinear
// weight per corner, the last marked by tlast, all with the same status
// (0 found, 1 left the element, 2 pass limit). All products run through one
// shared 32x32 multiplier; a locate first sets up the axes with three serial
// divisions, then runs at most 102 passes, then emits eight output words.
// Input is taken only while the block is idle; the last result word may
// still wait in the output register while the next word is taken.
module hex_element_inverse_mapping_top (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  output logic          in_tready,
  // [2:0] corner, [34:3] coord_x, [66:35] coord_y, [98:67] coord_z,
  // [129:99] distance_limit_sq, [135:130] zero
  input  logic [135:0]  in_tdata,
  // [0] func
  input  logic          in_tuser,
  output logic          out_tvalid,
  input  logic          out_tready,
  // [2:0] weight_index, [34:3] shape_weight, [36:35] status, [39:37] zero
  output logic [39:0]   out_tdata,
  output logic          out_tlast
);
  import hexinv_pkg::*;

  cmd_t               cmd;
  sts_t               sts;
  logic [2:0]         out_index;
  logic signed [31:0] out_weight;
  logic [1:0]         out_status;

  hexinv_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_func  (in_tuser),
    .in_ready (in_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  hexinv_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .in_corner  (in_tdata[2:0]),
    .in_coord_x (signed'(in_tdata[34:3])),
    .in_coord_y (signed'(in_tdata[66:35])),
    .in_coord_z (signed'(in_tdata[98:67])),
    .in_limit   (in_tdata[129:99]),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_index  (out_index),
    .out_weight (out_weight),
    .out_status (out_status),
    .out_last   (out_tlast)
  );

  // Pack the result word.
  assign out_tdata = {3'b000, out_status, out_weight, out_index};

endmodule
